// ===== src/i2p_pkg.sv =====
// Shared types, constants and character classification for the infix-to-postfix converter.
`default_nettype none

package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  typedef enum logic [1:0] {
    K_LETTER,
    K_LPAREN,
    K_RPAREN,
    K_OPER
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
    logic [1:0] prec;
    logic       last;
  } cmd_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_CARET) p = 2'd3;
    else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    else if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    return p;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic cmd_t classify(input logic [7:0] c, input logic last);
    cmd_t r;
    r.ch   = c;
    r.last = last;
    r.prec = prec_of(c);
    if (is_letter(c)) r.kind = K_LETTER;
    else if (c == CH_LPAREN) r.kind = K_LPAREN;
    else if (c == CH_RPAREN) r.kind = K_RPAREN;
    else r.kind = K_OPER;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/i2p_if.sv =====
// Valid/ready channel interfaces for the converter's input characters and postfix results.
`default_nettype none

interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       last_char;

  modport source (output valid, output in_char, output last_char, input ready);
  modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       end_of_expr;
  logic       overflow;

  modport source (output valid, output out_char, output has_char, output end_of_expr,
                  output overflow, input ready);
  modport sink   (input valid, input out_char, input has_char, input end_of_expr,
                  input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/i2p_front.sv =====
// Front end: accepts input characters and registers them as classified commands.
`default_nettype none

module i2p_front import i2p_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  i2p_in_if.sink    in_ch,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  wire logic cmd_ready
);

  logic hold_valid;
  cmd_t hold_cmd;

  assign in_ch.ready = !hold_valid || cmd_ready;
  assign cmd         = hold_cmd;
  assign cmd_valid   = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      hold_valid <= 1'b1;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold_cmd <= classify(in_ch.in_char, in_ch.last_char);
    end
  end

endmodule

`default_nettype wire

// ===== src/i2p_queue.sv =====
// Short command queue that decouples the front end from the stack engine.
`default_nettype none

module i2p_queue import i2p_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t wr_cmd,
  input  wire logic wr_valid,
  output logic      wr_ready,
  output cmd_t      rd_cmd,
  output logic      rd_valid,
  input  wire logic rd_ready
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = fill != QCNT_W'(QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= bump(wr_ptr);
      if (do_rd) rd_ptr <= bump(rd_ptr);
      if (do_wr && !do_rd) fill <= fill + 1'b1;
      else if (do_rd && !do_wr) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== src/i2p_back.sv =====
// Back end: operator stack engine that pops, pushes and flushes, with a registered result stage.
`default_nettype none

module i2p_back import i2p_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  hd,
  input  wire logic  hd_valid,
  output logic       deq,
  i2p_out_if.source  out_ch
);

  logic [7:0]       stack_mem [STACK_DEPTH];
  logic [7:0]       top;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] rd_ptr;
  logic             ovf;
  state_t           state;
  state_t           state_next;

  logic       out_valid;
  logic [7:0] o_char;
  logic       o_has;
  logic       o_end;
  logic       o_ovf;
  logic       out_free;

  logic       emit;
  logic [7:0] e_char;
  logic       e_has;
  logic       e_end;
  logic       pop;
  logic       push;
  logic       set_ovf;
  logic       clr;
  logic       want_push;
  logic       nonempty;

  assign out_free = !out_valid || out_ch.ready;
  assign nonempty = count != '0;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN:   if (deq && hd.last) state_next = ST_FLUSH;
      ST_FLUSH: if (clr) state_next = ST_RUN;
      default:  state_next = ST_RUN;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    e_char    = top;
    e_has     = 1'b1;
    e_end     = 1'b0;
    pop       = 1'b0;
    want_push = 1'b0;
    deq       = 1'b0;
    clr       = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (hd_valid) begin
          unique case (hd.kind)
            K_LETTER: begin
              if (out_free) begin
                emit   = 1'b1;
                e_char = hd.ch;
                deq    = 1'b1;
              end
            end
            K_LPAREN: begin
              want_push = 1'b1;
              deq       = 1'b1;
            end
            K_RPAREN: begin
              if (nonempty && top != CH_LPAREN) begin
                if (out_free) begin
                  emit = 1'b1;
                  pop  = 1'b1;
                end
              end else begin
                // The matching opening parenthesis is discarded.
                pop = nonempty;
                deq = 1'b1;
              end
            end
            K_OPER: begin
              if (nonempty && prec_of(top) >= hd.prec) begin
                if (out_free) begin
                  emit = 1'b1;
                  pop  = 1'b1;
                end
              end else begin
                want_push = 1'b1;
                deq       = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (!nonempty) begin
            // Nothing left to flush: a bare end marker is sent instead.
            e_char = '0;
            e_has  = 1'b0;
            e_end  = 1'b1;
            clr    = 1'b1;
          end else begin
            pop   = 1'b1;
            e_end = count == CNT_W'(1);
            clr   = count == CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign push    = want_push && count != CNT_W'(STACK_DEPTH);
  assign set_ovf = want_push && count == CNT_W'(STACK_DEPTH);

  always_comb begin
    if (clr) count_next = '0;
    else if (push) count_next = count + 1'b1;
    else if (pop) count_next = count - 1'b1;
    else count_next = count;
  end

  assign rd_ptr = count_next - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (clr) ovf <= 1'b0;
      else if (set_ovf) ovf <= 1'b1;
    end
  end

  // The top entry is kept in a register: a push writes it through, a pop
  // reads the entry below from the array.
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[count[ADDR_W-1:0]] <= hd.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (push) top <= hd.ch;
    else top <= stack_mem[rd_ptr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      o_char <= e_char;
      o_has  <= e_has;
      o_end  <= e_end;
      o_ovf  <= ovf;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_char    = o_char;
  assign out_ch.has_char    = o_has;
  assign out_ch.end_of_expr = o_end;
  assign out_ch.overflow    = o_ovf;

endmodule

`default_nettype wire

// ===== src/infix_to_postfix_converter_unit.sv =====
// Top level of the shunting-yard infix-to-postfix converter.
// A letter goes through the front-end register, a queue slot and the output register.
// The stack engine does one stack operation per cycle unless an emit waits on the output
// register; operators, closing parentheses and the final flush pop entries one at a time.
// The front end and a two-entry queue keep taking requests while the engine pops, until full.
// Synchronous reset empties the stack, queue and output register and clears overflow.
`default_nettype none

module infix_to_postfix_converter_unit import i2p_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  i2p_in_if.sink    in_ch,
  i2p_out_if.source out_ch
);

  cmd_t f_cmd;
  logic f_valid;
  logic f_ready;
  cmd_t q_cmd;
  logic q_valid;
  logic q_deq;

  i2p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  i2p_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_cmd   (f_cmd),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_cmd   (q_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_deq)
  );

  i2p_back u_back (
    .clk      (clk),
    .rst      (rst),
    .hd       (q_cmd),
    .hd_valid (q_valid),
    .deq      (q_deq),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ===== src/i2p_checker.sv =====
// Port-level checks on the converter's result stream, bound to the top level.
`default_nettype none

module i2p_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       has_char,
  input wire logic       end_of_expr
);

  localparam logic [7:0] RPAREN = 8'h29;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(has_char)
                                && $stable(end_of_expr))
    else $error("stalled result changed");

  a_blank_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> end_of_expr && out_char == 8'h00)
    else $error("empty result that is not an end marker");

  a_no_rparen: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_char |-> out_char != RPAREN)
    else $error("closing parenthesis emitted");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind infix_to_postfix_converter_unit i2p_checker u_i2p_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_char    (out_ch.out_char),
  .has_char    (out_ch.has_char),
  .end_of_expr (out_ch.end_of_expr)
);

`default_nettype wire
